### hw/rtl/ftm_pkg.sv
`default_nettype none

package ftm_pkg;

  localparam int unsigned TS_W       = 48;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned FILL_OUT_W = 7;
  localparam int unsigned ACC_W      = TICK_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_TICKS  = 1'b1;

  localparam logic [TICK_W-1:0] TICKS_PER_SECOND_RST = 32'd10000000;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIFF   = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_RATE   = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/ftm_in_if.sv
`default_nettype none

interface ftm_in_if;
  import ftm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TS_W-1:0]   timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

`default_nettype wire

### hw/rtl/ftm_out_if.sv
`default_nettype none

interface ftm_out_if;
  import ftm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TICK_W-1:0]     frame_ticks;
  logic [TICK_W-1:0]     average_ticks;
  logic [RATE_W-1:0]     frame_rate;
  logic                  sample_taken;
  logic [FILL_OUT_W-1:0] window_fill;

  modport source (output valid, output frame_ticks, output average_ticks,
                  output frame_rate, output sample_taken, output window_fill,
                  input ready);
  modport sink   (input valid, input frame_ticks, input average_ticks,
                  input frame_rate, input sample_taken, input window_fill,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/ftm_div.sv
`default_nettype none

module ftm_div #(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial  = {rem_r, quo_r[NUM_W-1]};
  assign diff   = trial - {1'b0, den_r};
  assign fits   = trial >= {1'b0, den_r};
  assign done_o = busy_r && (cnt_r == '0);
  assign quo_o  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= num_i;
      rem_r <= '0;
      den_r <= den_i;
    end else if (busy_r && (cnt_r != '0)) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |=> !busy_r)
    else $error("divider stayed busy after done");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && den_r != '0) |-> rem_r < den_r)
    else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

### hw/rtl/frame_time_meter.sv
// a poll is taken only in idle, then runs diff, check, update, rate, divide and done states
// window mean: serial divide of the SUM_W = 32 + clog2(WINDOW_DEPTH + 1) bit sum by the fill
// a new poll waits until the last one leaves done, which waits for a free result register
// a first poll only records its stamp; a poll held by the frame lock returns to idle from check
// reset: synchronous active-low rst_n; window memory is not cleared,
// fill count gates every read so no clearing pass is needed
`default_nettype none

module frame_time_meter #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ftm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ftm_pkg::TICK_W-1:0]     cfg_wdata,
  ftm_in_if.sink                              in_chan,
  ftm_out_if.source                           out_chan
);
  import ftm_pkg::*;

  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned SUM_W  = TICK_W + FILL_W;

  state_t state_r, state_nxt;

  logic [TICK_W-1:0] tps_r;
  logic [TICK_W-1:0] min_r;

  logic [TS_W-1:0]   last_stamp_r;
  logic              started_r;
  logic [TS_W-1:0]   ts_r;
  logic [TICK_W-1:0] elapsed_r;
  logic [TICK_W-1:0] gap_r;
  logic [TICK_W-1:0] mean_r;
  logic [FILL_W-1:0] fill_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [SUM_W-1:0]  sum_r;
  logic [RATE_W-1:0] frames_r;
  logic [ACC_W-1:0]  acc_r;
  logic [RATE_W-1:0] last_rate_r;
  logic              taken_r;

  logic [TICK_W-1:0] mem [WINDOW_DEPTH];
  logic [TICK_W-1:0] rd_r;

  logic              out_valid_r;
  logic [TICK_W-1:0] out_frame_r;
  logic [TICK_W-1:0] out_avg_r;
  logic [RATE_W-1:0] out_rate_r;
  logic              out_taken_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  logic [TS_W-1:0]   diff;
  logic              in_fire;
  logic              lock_pending;
  logic              taken;
  logic              full;
  logic [TICK_W-1:0] dropped;
  logic              mem_we;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic              out_load;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign diff          = ts_r - last_stamp_r;
  assign lock_pending  = (min_r != '0) && (elapsed_r < min_r);
  assign taken         = gap_r < tps_r;
  assign full          = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign dropped       = full ? rd_r : '0;
  assign mem_we        = (state_r == ST_UPDATE) && taken;
  assign div_start     = (state_r == ST_RATE);
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  ftm_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (sum_r),
    .den_i   (fill_r),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && started_r) state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = lock_pending ? ST_IDLE : ST_UPDATE;
      ST_UPDATE: state_nxt = ST_RATE;
      ST_RATE:   state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tps_r   <= TICKS_PER_SECOND_RST;
      min_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TICKS_PER_SECOND: tps_r <= cfg_wdata;
          REG_MIN_FRAME_TICKS:  min_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      started_r    <= 1'b0;
      mean_r       <= '0;
      fill_r       <= '0;
      ptr_r        <= '0;
      sum_r        <= '0;
      frames_r     <= '0;
      acc_r        <= '0;
      last_rate_r  <= '0;
    end else begin
      if (in_fire && !started_r) begin
        last_stamp_r <= in_chan.timestamp;
        started_r    <= 1'b1;
      end
      if ((state_r == ST_CHECK) && !lock_pending) begin
        last_stamp_r <= ts_r;
      end
      if (state_r == ST_UPDATE) begin
        if (taken) begin
          ptr_r <= (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
          sum_r <= sum_r + SUM_W'(elapsed_r) - SUM_W'(dropped);
        end
        if (frames_r != '1) begin
          frames_r <= frames_r + 1'b1;
        end
        acc_r <= acc_r + {1'b0, elapsed_r};
      end
      if ((state_r == ST_RATE) && (acc_r > {1'b0, tps_r})) begin
        last_rate_r <= frames_r;
        frames_r    <= '0;
        acc_r       <= '0;
      end
      if (state_r == ST_DIV && div_done) begin
        mean_r <= (fill_r == '0) ? '0 : div_quo[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ts_r <= in_chan.timestamp;
    end
    if (state_r == ST_DIFF) begin
      elapsed_r <= (diff[TS_W-1:TICK_W] != '0) ? '1 : diff[TICK_W-1:0];
    end
    if (state_r == ST_CHECK) begin
      gap_r <= (elapsed_r >= mean_r) ? (elapsed_r - mean_r) : (mean_r - elapsed_r);
    end
    if (state_r == ST_UPDATE) begin
      taken_r <= taken;
    end
  end

  // sample window, oldest entry sits at the write pointer once full
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= elapsed_r;
    end
    rd_r <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r <= elapsed_r;
      out_avg_r   <= mean_r;
      out_rate_r  <= last_rate_r;
      out_taken_r <= taken_r;
      out_fill_r  <= FILL_OUT_W'(fill_r);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.frame_ticks   = out_frame_r;
  assign out_chan.average_ticks = out_avg_r;
  assign out_chan.frame_rate    = out_rate_r;
  assign out_chan.sample_taken  = out_taken_r;
  assign out_chan.window_fill   = out_fill_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word not from done state");
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide state");
  a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped");
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (acc_r <= {1'b0, tps_r}))
    else $error("second accumulator not cleared on rollover");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ftm_pkg::*;

  localparam int unsigned DEPTH           = 64;
  localparam int unsigned SETTLE_CYCLES   = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned FRAMES_PER_PHASE = 135;

  typedef struct packed {
    bit [TICK_W-1:0]     frame_ticks;
    bit [TICK_W-1:0]     average_ticks;
    bit [RATE_W-1:0]     frame_rate;
    bit                  sample_taken;
    bit [FILL_OUT_W-1:0] window_fill;
  } frame_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_wdata;

  ftm_in_if  in_bus();
  ftm_out_if out_bus();

  frame_time_meter #(.WINDOW_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_bus),
    .out_chan  (out_bus)
  );

  // meter state as the block should hold it
  bit [TICK_W-1:0] tps_reg;
  bit [TICK_W-1:0] min_ticks_reg;
  bit [TS_W-1:0]   prev_stamp;
  bit              timing_started;
  bit [TICK_W-1:0] recent_frames[$];
  bit [TICK_W-1:0] avg_ticks;
  bit [RATE_W-1:0] frame_count;
  bit [ACC_W-1:0]  span_ticks;
  bit [RATE_W-1:0] rate_reg;

  frame_report_t frame_reports[$];
  int unsigned   mismatches = 0;
  int unsigned   idle_cycles = 0;
  bit            steady_flow = 1'b0;
  bit            hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void reset_meter_model();
    tps_reg        = TICKS_PER_SECOND_RST;
    min_ticks_reg  = '0;
    prev_stamp     = '0;
    timing_started = 1'b0;
    recent_frames.delete();
    avg_ticks      = '0;
    frame_count    = '0;
    span_ticks     = '0;
    rate_reg       = '0;
  endfunction

  function automatic bit meter_poll(input bit [TS_W-1:0] stamp, output frame_report_t rep);
    bit [TS_W-1:0]   delta;
    bit [TICK_W-1:0] elapsed;
    bit [TICK_W-1:0] spread;
    bit              took;
    bit [63:0]       total;
    rep = '0;
    if (!timing_started) begin
      prev_stamp = stamp;
      timing_started = 1'b1;
      return 1'b0;
    end
    delta = stamp - prev_stamp;
    elapsed = (delta > TS_W'(32'hFFFF_FFFF)) ? '1 : delta[TICK_W-1:0];
    // frame lock still pending
    if (min_ticks_reg != 0 && elapsed < min_ticks_reg) return 1'b0;
    prev_stamp = stamp;
    spread = (elapsed >= avg_ticks) ? elapsed - avg_ticks : avg_ticks - elapsed;
    took = spread < tps_reg;
    if (took) begin
      recent_frames.push_front(elapsed);
      if (recent_frames.size() > DEPTH) void'(recent_frames.pop_back());
    end
    if (frame_count != '1) frame_count++;
    span_ticks += elapsed;
    if (span_ticks > tps_reg) begin
      rate_reg = frame_count;
      frame_count = '0;
      span_ticks = '0;
    end
    total = '0;
    foreach (recent_frames[k]) total += recent_frames[k];
    avg_ticks = (recent_frames.size() == 0) ? '0 : TICK_W'(total / 64'(recent_frames.size()));
    rep.frame_ticks   = elapsed;
    rep.average_ticks = avg_ticks;
    rep.frame_rate    = rate_reg;
    rep.sample_taken  = took;
    rep.window_fill   = FILL_OUT_W'(recent_frames.size());
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [TICK_W-1:0] got,
                                      logic [TICK_W-1:0] want);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    frame_report_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (frame_reports.size() == 0) begin
        $error("unexpected word: frame_ticks %0d", out_bus.frame_ticks);
        mismatches++;
      end else begin
        want = frame_reports.pop_front();
        check_field("frame_ticks", out_bus.frame_ticks, want.frame_ticks);
        check_field("average_ticks", out_bus.average_ticks, want.average_ticks);
        check_field("frame_rate", out_bus.frame_rate, want.frame_rate);
        check_field("sample_taken", out_bus.sample_taken, want.sample_taken);
        check_field("window_fill", out_bus.window_fill, want.window_fill);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned span;
    bit          hold_served;
    hold_served = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending && !hold_served) begin
        hold_served = 1'b1;
        out_bus.ready <= 1'b0;
        span = HOLD_OFF_CYCLES;
      end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        span = $urandom_range(1, 19);
      end else begin
        out_bus.ready <= 1'b1;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  task automatic send_poll(input bit [TS_W-1:0] stamp, output bit produced);
    frame_report_t rep;
    in_bus.valid <= 1'b1;
    in_bus.timestamp <= stamp;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    produced = meter_poll(stamp, rep);
    if (produced) frame_reports.push_back(rep);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic poll_after(input bit [TS_W-1:0] elapsed);
    bit produced;
    send_poll(prev_stamp + elapsed, produced);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (frame_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [TICK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TICKS_PER_SECOND: tps_reg = value;
      REG_MIN_FRAME_TICKS:  min_ticks_reg = value;
      default: ;
    endcase
  endtask

  task automatic configure(input bit [TICK_W-1:0] tps, input bit [TICK_W-1:0] min_ticks);
    drain_results();
    write_reg(REG_TICKS_PER_SECOND, tps);
    write_reg(REG_MIN_FRAME_TICKS, min_ticks);
  endtask

  task automatic test_first_poll_and_wrap();
    bit produced;
    send_poll(48'hFFFF_FFFF_FFFF, produced);
    // wraps through zero, saturates, lands in an empty window
    send_poll(48'h0000_FFFF_FFFF, produced);
    send_poll(48'h0001_FFFF_FFFE, produced);
    poll_after(1);
    poll_after(0);
    poll_after(166_667);
    poll_after(166_667);
    poll_after(TS_W'(avg_ticks) + TS_W'(tps_reg));
    poll_after(TS_W'(avg_ticks) + TS_W'(tps_reg) - 1);
    send_poll(48'h8000_0000_0000, produced);
  endtask

  task automatic test_frame_lock();
    configure(32'd10_000, 32'd1_000);
    poll_after(999);
    poll_after(1_000);
    poll_after(1);
    poll_after(500);
    poll_after(1_500);
    configure(32'd10_000, 32'hFFFF_FFFF);
    poll_after(7);
    poll_after(48'h1_0000_0000);
  endtask

  task automatic test_second_rollover();
    configure(32'd100, 32'd0);
    poll_after(150);
    repeat (4) poll_after(25);
    poll_after(1);
    configure(32'd1, 32'd0);
    poll_after(2);
    poll_after(1);
    poll_after(1);
    configure(32'hFFFF_FFFF, 32'd0);
    poll_after(48'h0_FFFF_FFFF);
    poll_after(1);
  endtask

  function automatic bit [TS_W-1:0] pick_stamp(input bit [TS_W-1:0] period);
    bit [TS_W-1:0] jitter;
    bit [TS_W-1:0] e;
    int unsigned   roll;
    jitter = period >> 4;
    roll = $urandom_range(0, 99);
    if (roll < 8 && min_ticks_reg != 0)
      e = TS_W'($urandom_range(0, min_ticks_reg - 1));
    else if (roll < 13)
      e = TS_W'(avg_ticks) + TS_W'(tps_reg) - 1 + TS_W'($urandom_range(0, 2));
    else if (roll < 16 && avg_ticks >= tps_reg)
      e = TS_W'(avg_ticks) - TS_W'(tps_reg) + TS_W'($urandom_range(0, 1));
    else if (roll < 20)
      e = TS_W'($urandom);
    else if (roll < 23)
      return TS_W'({$urandom, $urandom});
    else if (roll < 25)
      return {TS_W{1'b1}} - period * TS_W'($urandom_range(0, 4));
    else
      e = period - jitter + TS_W'($urandom_range(0, 32'(2 * jitter)));
    return prev_stamp + e;
  endfunction

  task automatic test_random_frames();
    int unsigned     phase;
    int unsigned     frames;
    int unsigned     rate;
    bit [TICK_W-1:0] tps;
    bit [TICK_W-1:0] min_ticks;
    bit [TS_W-1:0]   period;
    bit              produced;
    for (phase = 0; phase < PHASES; phase++) begin
      rate = $urandom_range(1, 150);
      case (phase)
        0, PHASES - 1: begin tps = 32'd10_000_000; rate = 60; end
        1: tps = 32'd1;
        2: tps = 32'hFFFF_FFFF;
        3: tps = 32'd1_000;
        default: tps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'hFFFF_FFFF)
                                                   : $urandom_range(20, 20_000_000);
      endcase
      period = TS_W'(tps / rate);
      if (period == 0) period = 1;
      case ($urandom_range(0, 3))
        0: min_ticks = TICK_W'(period * 3 / 4);
        1: min_ticks = TICK_W'(period);
        default: min_ticks = '0;
      endcase
      if (phase == 0 || phase == PHASES - 1) min_ticks = '0;
      if (phase == 3) min_ticks = TICK_W'(period * 3 / 4);
      configure(tps, min_ticks);
      if (phase == 2) hold_pending = 1'b1;
      if (phase == PHASES - 1) steady_flow = 1'b1;
      frames = 0;
      while (frames < FRAMES_PER_PHASE) begin
        send_poll(pick_stamp(period), produced);
        frames++;
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.timestamp <= '0;
    reset_meter_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_poll_and_wrap();
    test_frame_lock();
    test_second_rollover();
    test_random_frames();
    drain_results();
    if (mismatches == 0 && frame_reports.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
